[hdl/tfn_pkg.sv]
package tfn_pkg;

	localparam int IDX_W      = 12;
	localparam int FIELD_W    = 16;
	localparam int A_W        = 31;
	localparam int SUM_W      = 64;
	localparam int ROOT_W     = 32;
	localparam int ROOT_STEPS = 32;
	localparam int Q_BITS     = 15;
	localparam int NUM_W      = 47;
	localparam int FRAC_BITS  = 14;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_NORMAL = 1'b1;

	typedef enum logic [1:0] {
		FETCH_IDLE,
		FETCH_B,
		FETCH_C
	} fetch_state_t;

	typedef struct packed {
		logic       valid;
		logic       degen;
		logic       last;
		logic [2:0] neg;
	} ctrl_t;

endpackage

[hdl/triangle_face_normal.sv]
// Vertex write: one per cycle while idle and not stalled, a single store access.
// Triangle: the next waits for the three corner reads on the one-port store.
// A triangle passes the corner reads, s1..s8, a 32-step root and a 15-step divide.
// Holding out_ready low while out_valid is high freezes the whole pipeline.
// Reset clears control and valid flags; the vertex store is not cleared.
module triangle_face_normal
	import tfn_pkg::*;
#(
	parameter int VERTEX_DEPTH = 4096,
	parameter int COORD_WIDTH  = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      operation,
	input  logic [IDX_W-1:0]          vertex_index,
	input  logic signed [FIELD_W-1:0] coord_x,
	input  logic signed [FIELD_W-1:0] coord_y,
	input  logic signed [FIELD_W-1:0] coord_z,
	input  logic [IDX_W-1:0]          corner_a,
	input  logic [IDX_W-1:0]          corner_b,
	input  logic [IDX_W-1:0]          corner_c,
	input  logic                      last_in_mesh,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [FIELD_W-1:0] normal_x,
	output logic signed [FIELD_W-1:0] normal_y,
	output logic signed [FIELD_W-1:0] normal_z,
	output logic                      degenerate,
	output logic                      last_normal
);

	localparam int AW  = $clog2(VERTEX_DEPTH);
	localparam int CW  = COORD_WIDTH;
	localparam int VW  = 3 * CW;
	localparam int DW  = CW + 1;
	localparam int PW  = 2 * DW;
	localparam int NW  = PW + 1;
	localparam int PSW = $clog2(NW);
	localparam int SHW = NW + A_W - 1;

	// handshake and fetch sequencer
	fetch_state_t state_q, state_d;
	logic         stall, adv, acc;
	logic         ram_en, ram_we;
	logic [AW-1:0] ram_addr;
	logic [VW-1:0] ram_wdata, ram_rdata;
	logic         wr_ok, a_ok;

	logic [IDX_W-1:0] corner_b_q, corner_c_q;
	logic             ok_a_q, ok_b_q, ok_c_q, last_q, cap_c_q;
	logic [VW-1:0]    pa_q, pb_q;

	logic out_valid_q;

	assign stall = out_valid_q & ~out_ready;
	assign adv   = ~stall;
	assign acc   = in_valid & in_ready;
	assign wr_ok = 32'(vertex_index) < 32'(VERTEX_DEPTH);
	assign a_ok  = 32'(corner_a) < 32'(VERTEX_DEPTH);

	logic [CW+FIELD_W-1:0] xe, ye, ze;
	assign xe        = {{CW{1'b0}}, coord_x};
	assign ye        = {{CW{1'b0}}, coord_y};
	assign ze        = {{CW{1'b0}}, coord_z};
	assign ram_wdata = {ze[CW-1:0], ye[CW-1:0], xe[CW-1:0]};

	always_comb begin
		state_d = state_q;
		case (state_q)
			FETCH_IDLE: if (acc && operation == OP_NORMAL) state_d = FETCH_B;
			FETCH_B:    if (adv) state_d = FETCH_C;
			FETCH_C:    if (adv) state_d = FETCH_IDLE;
			default:    state_d = FETCH_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		ram_en   = 1'b0;
		ram_we   = 1'b0;
		ram_addr = AW'(corner_a);
		case (state_q)
			FETCH_IDLE: begin
				in_ready = adv;
				ram_we   = (operation == OP_WRITE);
				ram_en   = acc & ((operation == OP_WRITE) ? wr_ok : 1'b1);
				ram_addr = (operation == OP_WRITE) ? AW'(vertex_index) : AW'(corner_a);
			end
			FETCH_B: begin
				ram_en   = adv;
				ram_addr = AW'(corner_b_q);
			end
			FETCH_C: begin
				ram_en   = adv;
				ram_addr = AW'(corner_c_q);
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	tfn_ram #(
		.WIDTH(VW),
		.DEPTH(VERTEX_DEPTH)
	) u_store (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FETCH_IDLE;
			cap_c_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (adv) begin
				cap_c_q <= (state_q == FETCH_C);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && operation == OP_NORMAL) begin
			corner_b_q <= corner_b;
			corner_c_q <= corner_c;
			ok_a_q     <= a_ok;
			ok_b_q     <= 32'(corner_b) < 32'(VERTEX_DEPTH);
			ok_c_q     <= 32'(corner_c) < 32'(VERTEX_DEPTH);
			last_q     <= last_in_mesh;
		end
		if (adv && state_q == FETCH_B) begin
			pa_q <= ok_a_q ? ram_rdata : '0;
		end
		if (adv && state_q == FETCH_C) begin
			pb_q <= ok_b_q ? ram_rdata : '0;
		end
	end

	// s1: edge vectors
	logic [VW-1:0]          pc_w;
	logic signed [DW-1:0]   v1_s1 [3];
	logic signed [DW-1:0]   v2_s1 [3];
	ctrl_t                  ctrl_s1;

	assign pc_w = ok_c_q ? ram_rdata : '0;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				v1_s1[k] <= DW'($signed(pa_q[k*CW +: CW])) - DW'($signed(pc_w[k*CW +: CW]));
				v2_s1[k] <= DW'($signed(pc_w[k*CW +: CW])) - DW'($signed(pb_q[k*CW +: CW]));
			end
		end
	end

	// s2: six products
	logic signed [PW-1:0] prod_s2 [6];
	ctrl_t                ctrl_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2[0] <= v1_s1[1] * v2_s1[2];
			prod_s2[1] <= v1_s1[2] * v2_s1[1];
			prod_s2[2] <= v1_s1[2] * v2_s1[0];
			prod_s2[3] <= v1_s1[0] * v2_s1[2];
			prod_s2[4] <= v1_s1[0] * v2_s1[1];
			prod_s2[5] <= v1_s1[1] * v2_s1[0];
		end
	end

	// s3: cross product
	logic signed [NW-1:0] n_s3 [3];
	ctrl_t                ctrl_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				n_s3[k] <= NW'(prod_s2[2*k]) - NW'(prod_s2[2*k+1]);
			end
		end
	end

	// s4: magnitudes and their union
	logic [NW-1:0] mag_s4 [3];
	logic [NW-1:0] orw_s4;
	ctrl_t         ctrl_s4;
	logic [NW-1:0] mag_w [3];
	logic [2:0]    neg_w;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			neg_w[k] = n_s3[k][NW-1];
			mag_w[k] = neg_w[k] ? NW'(-n_s3[k]) : NW'(n_s3[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s4 <= mag_w;
			orw_s4 <= mag_w[0] | mag_w[1] | mag_w[2];
		end
	end

	// s5: leading-one position of the largest magnitude
	logic [NW-1:0]  mag_s5 [3];
	logic [PSW-1:0] pos_s5;
	ctrl_t          ctrl_s5;
	logic [PSW-1:0] pos_w;

	always_comb begin
		pos_w = '0;
		for (int k = 0; k < NW; k++) begin
			if (orw_s4[k]) pos_w = PSW'(k);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s5 <= mag_s4;
			pos_s5 <= pos_w;
		end
	end

	// s6: normalise so the largest lies in [2^30, 2^31)
	logic [A_W-1:0] a_s6 [3];
	ctrl_t          ctrl_s6;
	logic [SHW-1:0] sh_w [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sh_w[k] = {mag_s5[k], {(A_W-1){1'b0}}} >> pos_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				a_s6[k] <= sh_w[k][A_W-1:0];
			end
		end
	end

	// s7: squares
	logic [A_W-1:0]   a_s7 [3];
	logic [2*A_W-1:0] sq_s7 [3];
	ctrl_t            ctrl_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s7 <= a_s6;
			for (int k = 0; k < 3; k++) begin
				sq_s7[k] <= a_s6[k] * a_s6[k];
			end
		end
	end

	// s8: sum of squares
	logic [3*A_W-1:0] a_s8;
	logic [SUM_W-1:0] sum_s8;
	ctrl_t            ctrl_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s8   <= {a_s7[2], a_s7[1], a_s7[0]};
			sum_s8 <= SUM_W'(sq_s7[0]) + SUM_W'(sq_s7[1]) + SUM_W'(sq_s7[2]);
		end
	end

	// control sideband through s1..s8
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
			ctrl_s4 <= '0;
			ctrl_s5 <= '0;
			ctrl_s6 <= '0;
			ctrl_s7 <= '0;
			ctrl_s8 <= '0;
		end else if (adv) begin
			ctrl_s1 <= '{valid: cap_c_q, degen: 1'b0, last: last_q, neg: 3'b000};
			ctrl_s2 <= ctrl_s1;
			ctrl_s3 <= ctrl_s2;
			ctrl_s4 <= '{valid: ctrl_s3.valid, degen: ctrl_s3.degen, last: ctrl_s3.last,
				neg: neg_w};
			ctrl_s5 <= '{valid: ctrl_s4.valid, degen: (orw_s4 == '0), last: ctrl_s4.last,
				neg: ctrl_s4.neg};
			ctrl_s6 <= ctrl_s5;
			ctrl_s7 <= ctrl_s6;
			ctrl_s8 <= ctrl_s7;
		end
	end

	// square root
	ctrl_t            rt_ctrl;
	logic [3*A_W-1:0] rt_side;
	logic [ROOT_W-1:0] rt_len;

	tfn_isqrt #(
		.SIDE_W(3 * A_W)
	) u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_ctrl (ctrl_s8),
		.in_side (a_s8),
		.in_val  (sum_s8),
		.out_ctrl(rt_ctrl),
		.out_side(rt_side),
		.out_root(rt_len)
	);

	// rounded numerators
	logic [NUM_W-1:0]  num_q [3];
	logic [ROOT_W-1:0] len_q;
	ctrl_t             ctrl_num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_num_q <= '0;
		end else if (adv) begin
			ctrl_num_q <= rt_ctrl;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			len_q <= rt_len;
			for (int k = 0; k < 3; k++) begin
				num_q[k] <= {2'b00, rt_side[k*A_W +: A_W], {FRAC_BITS{1'b0}}}
					+ NUM_W'(rt_len >> 1);
			end
		end
	end

	// restoring divide, one quotient bit per stage
	ctrl_t             dv_ctrl_s [Q_BITS];
	logic [ROOT_W-1:0] dv_len_s  [Q_BITS];
	logic [NUM_W-1:0]  dv_rem_s  [Q_BITS][3];
	logic [Q_BITS-1:0] dv_q_s    [Q_BITS][3];

	for (genvar j = 0; j < Q_BITS; j++) begin : g_div
		localparam int SH = Q_BITS - 1 - j;
		ctrl_t             c_in;
		logic [ROOT_W-1:0] l_in;
		logic [NUM_W-1:0]  r_in [3];
		logic [Q_BITS-1:0] q_in [3];
		logic [NUM_W-1:0]  dsr;

		if (j == 0) begin : g_first
			assign c_in = ctrl_num_q;
			assign l_in = len_q;
			assign r_in = num_q;
			assign q_in = '{default: '0};
		end else begin : g_next
			assign c_in = dv_ctrl_s[j-1];
			assign l_in = dv_len_s[j-1];
			assign r_in = dv_rem_s[j-1];
			assign q_in = dv_q_s[j-1];
		end

		assign dsr = NUM_W'(l_in) << SH;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_ctrl_s[j] <= '0;
			end else if (adv) begin
				dv_ctrl_s[j] <= c_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_len_s[j] <= l_in;
				for (int k = 0; k < 3; k++) begin
					if (r_in[k] >= dsr) begin
						dv_rem_s[j][k] <= r_in[k] - dsr;
						dv_q_s[j][k]   <= q_in[k] | (Q_BITS'(1) << SH);
					end else begin
						dv_rem_s[j][k] <= r_in[k];
						dv_q_s[j][k]   <= q_in[k];
					end
				end
			end
		end
	end

	// output register
	ctrl_t                     fin_ctrl;
	logic signed [FIELD_W-1:0] res_w [3];
	logic signed [FIELD_W-1:0] nx_q, ny_q, nz_q;
	logic                      degen_q, last_out_q;

	assign fin_ctrl = dv_ctrl_s[Q_BITS-1];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (fin_ctrl.degen) begin
				res_w[k] = '0;
			end else if (fin_ctrl.neg[k]) begin
				res_w[k] = -FIELD_W'(dv_q_s[Q_BITS-1][k]);
			end else begin
				res_w[k] = FIELD_W'(dv_q_s[Q_BITS-1][k]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= fin_ctrl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && fin_ctrl.valid) begin
			nx_q       <= res_w[0];
			ny_q       <= res_w[1];
			nz_q       <= res_w[2];
			degen_q    <= fin_ctrl.degen;
			last_out_q <= fin_ctrl.last;
		end
	end

	assign out_valid   = out_valid_q;
	assign normal_x    = nx_q;
	assign normal_y    = ny_q;
	assign normal_z    = nz_q;
	assign degenerate  = degen_q;
	assign last_normal = last_out_q;

`ifndef NO_ASSERTIONS
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != FETCH_IDLE |-> !in_ready)
		else $error("ready raised during corner fetch");

	a_stall_holds_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> $stable(state_q))
		else $error("fetch sequencer moved while stalled");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
		else $error("degenerate result with non-zero normal");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> normal_x <= 16'sd16384 && normal_x >= -16'sd16384
			&& normal_z <= 16'sd16384 && normal_z >= -16'sd16384)
		else $error("normal component beyond unit range");
`endif

endmodule

[hdl/tfn_ram.sv]
module tfn_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             en,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

[hdl/tfn_isqrt.sv]
module tfn_isqrt
	import tfn_pkg::*;
#(
	parameter int SIDE_W = 93
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  ctrl_t             in_ctrl,
	input  logic [SIDE_W-1:0] in_side,
	input  logic [SUM_W-1:0]  in_val,
	output ctrl_t             out_ctrl,
	output logic [SIDE_W-1:0] out_side,
	output logic [ROOT_W-1:0] out_root
);

	ctrl_t             ctrl_s [ROOT_STEPS];
	logic [SIDE_W-1:0] side_s [ROOT_STEPS];
	logic [SUM_W-1:0]  x_s    [ROOT_STEPS];
	logic [SUM_W-1:0]  r_s    [ROOT_STEPS];

	for (genvar i = 0; i < ROOT_STEPS; i++) begin : g_step
		localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2 * i);
		ctrl_t             c_in;
		logic [SIDE_W-1:0] d_in;
		logic [SUM_W-1:0]  x_in;
		logic [SUM_W-1:0]  r_in;
		logic [SUM_W-1:0]  trial;

		if (i == 0) begin : g_first
			assign c_in = in_ctrl;
			assign d_in = in_side;
			assign x_in = in_val;
			assign r_in = '0;
		end else begin : g_next
			assign c_in = ctrl_s[i-1];
			assign d_in = side_s[i-1];
			assign x_in = x_s[i-1];
			assign r_in = r_s[i-1];
		end

		assign trial = r_in + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctrl_s[i] <= '0;
			end else if (adv) begin
				ctrl_s[i] <= c_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				side_s[i] <= d_in;
				if (x_in >= trial) begin
					x_s[i] <= x_in - trial;
					r_s[i] <= (r_in >> 1) + BIT;
				end else begin
					x_s[i] <= x_in;
					r_s[i] <= r_in >> 1;
				end
			end
		end
	end

	assign out_ctrl = ctrl_s[ROOT_STEPS-1];
	assign out_side = side_s[ROOT_STEPS-1];
	assign out_root = r_s[ROOT_STEPS-1][ROOT_W-1:0];

endmodule
